@@ rtl/prq_pkg.sv @@
// Shared types and codes for the priority ready queue.
package prq_pkg;
    localparam int TAG_W  = 8;
    localparam int PRIO_W = 16;
    localparam int RUN_W  = 2;
    localparam int OCC_W  = 5;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_PICK = 2'd2;
    localparam logic [1:0] OP_SET  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_NONE  = 2'd3;

    localparam logic [1:0] RUN_READY   = 2'd0;
    localparam logic [1:0] RUN_RUNNING = 2'd1;

    typedef struct packed {
        logic [1:0]        operation;
        logic [TAG_W-1:0]  thread_tag;
        logic [PRIO_W-1:0] priority_req;
        logic [RUN_W-1:0]  new_state;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [TAG_W-1:0]  chosen_tag;
        logic [PRIO_W-1:0] chosen_priority;
        logic [OCC_W-1:0]  occupancy;
    } t_rsp;
endpackage

@@ rtl/prq_if.sv @@
// Valid/ready channel interfaces for requests and results.
interface prq_req_if;
    logic          valid;
    logic          ready;
    prq_pkg::t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface prq_rsp_if;
    logic          valid;
    logic          ready;
    prq_pkg::t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/prq_front.sv @@
// Front end: accepts requests into a two-entry queue for the cell array.
module prq_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    prq_req_if.sink       req,
    output logic          o_valid,
    output prq_pkg::t_req o_req,
    input  logic          i_take
);
    prq_pkg::t_req r_q [2];
    logic [1:0] r_cnt;
    logic       push, pop;

    assign req.ready = (r_cnt != 2'd2);
    assign push      = req.valid && req.ready;
    assign o_valid   = (r_cnt != 2'd0);
    assign o_req     = r_q[0];
    assign pop       = o_valid && i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (pop) begin
            r_q[0] <= r_q[1];
        end
        if (push) begin
            if (pop) r_q[r_cnt[1] ? 1 : 0] <= req.payload;
            else     r_q[r_cnt[0] ? 1 : 0] <= req.payload;
        end
    end
endmodule

@@ rtl/prq_cells.sv @@
// Back end: sorted cell chain that executes one request at a time.
module prq_cells #(
    parameter int THREADS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  prq_pkg::t_req i_req,
    output logic          o_take,
    prq_rsp_if.source     rsp
);
    localparam int CW = $clog2(THREADS + 1);
    localparam int IW = (THREADS > 1) ? $clog2(THREADS) : 1;

    typedef enum logic {S_EVAL, S_DO} t_state;

    logic [prq_pkg::TAG_W-1:0]  r_tag  [THREADS];
    logic [prq_pkg::PRIO_W-1:0] r_prio [THREADS];
    logic [prq_pkg::RUN_W-1:0]  r_run  [THREADS];
    logic [CW-1:0]              r_cnt;
    t_state                     r_state;
    prq_pkg::t_req              r_req;
    logic [THREADS-1:0]         r_hit;   // per-cell match from eval cycle
    logic                       r_ovalid;
    prq_pkg::t_rsp              r_out;

    logic [THREADS-1:0] n_hit, first;
    logic               any;
    logic [IW-1:0]      idx;
    prq_pkg::t_rsp      n_out;

    assign o_take    = i_valid && (r_state == S_EVAL) && (!r_ovalid || rsp.ready);
    assign rsp.valid = r_ovalid;
    assign rsp.payload = r_out;

    always_comb begin
        for (int i = 0; i < THREADS; i++) begin
            logic live;
            live = (i < r_cnt);
            case (i_req.operation)
                prq_pkg::OP_ADD:  n_hit[i] = live && (r_prio[i] < i_req.priority_req);
                prq_pkg::OP_POP:  n_hit[i] = (i == 0) && live;
                prq_pkg::OP_PICK: n_hit[i] = live && (r_run[i] == prq_pkg::RUN_READY)
                                  && (r_prio[i] > i_req.priority_req);
                default:          n_hit[i] = live && (r_tag[i] == i_req.thread_tag);
            endcase
        end
    end

    // first set bit of the registered match vector
    always_comb begin
        first = r_hit & (~r_hit + THREADS'(1));
        any   = |r_hit;
        idx   = '0;
        for (int i = 0; i < THREADS; i++) if (first[i]) idx = IW'(i);
    end

    always_comb begin
        n_out = '0;
        n_out.occupancy = prq_pkg::OCC_W'(r_cnt);
        case (r_req.operation)
            prq_pkg::OP_ADD: begin
                if (r_cnt == CW'(THREADS)) n_out.status = prq_pkg::ST_FULL;
                else n_out.occupancy = prq_pkg::OCC_W'(r_cnt + CW'(1));
            end
            prq_pkg::OP_POP: begin
                if (r_cnt == '0) n_out.status = prq_pkg::ST_EMPTY;
                else begin
                    n_out.chosen_tag      = r_tag[0];
                    n_out.chosen_priority = r_prio[0];
                    n_out.occupancy       = prq_pkg::OCC_W'(r_cnt - CW'(1));
                end
            end
            prq_pkg::OP_PICK: begin
                if (r_cnt == '0) n_out.status = prq_pkg::ST_EMPTY;
                else if (!any) n_out.status = prq_pkg::ST_NONE;
                else begin
                    n_out.chosen_tag      = r_tag[idx];
                    n_out.chosen_priority = r_prio[idx];
                end
            end
            default: begin
                if (r_cnt == '0) n_out.status = prq_pkg::ST_EMPTY;
                else if (!any) n_out.status = prq_pkg::ST_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_EVAL;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (rsp.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_EVAL: begin
                    if (o_take) begin
                        r_req   <= i_req;
                        r_hit   <= n_hit;
                        r_state <= S_DO;
                    end
                end
                S_DO: begin
                    r_out    <= n_out;
                    r_ovalid <= 1'b1;
                    r_state  <= S_EVAL;
                    case (r_req.operation)
                        prq_pkg::OP_ADD: if (r_cnt != CW'(THREADS)) begin
                            r_cnt <= r_cnt + CW'(1);
                            for (int i = 0; i < THREADS; i++) begin
                                logic at, above;
                                at    = any ? first[i] : (i == r_cnt);
                                above = (i > 0) && (r_hit & ((THREADS'(1) << i) - THREADS'(1))) != '0;
                                if (at) begin
                                    r_tag[i]  <= r_req.thread_tag;
                                    r_prio[i] <= r_req.priority_req;
                                    r_run[i]  <= r_req.new_state;
                                end else if (above && (i <= r_cnt)) begin
                                    r_tag[i]  <= r_tag[i-1];
                                    r_prio[i] <= r_prio[i-1];
                                    r_run[i]  <= r_run[i-1];
                                end
                            end
                        end
                        prq_pkg::OP_POP: if (r_cnt != '0) begin
                            r_cnt <= r_cnt - CW'(1);
                            for (int i = 0; i + 1 < THREADS; i++) begin
                                r_tag[i]  <= r_tag[i+1];
                                r_prio[i] <= r_prio[i+1];
                                r_run[i]  <= r_run[i+1];
                            end
                        end
                        prq_pkg::OP_PICK: if (any) r_run[idx] <= prq_pkg::RUN_RUNNING;
                        default:          if (any) r_run[idx] <= r_req.new_state;
                    endcase
                end
                default: r_state <= S_EVAL;
            endcase
        end
    end
endmodule

@@ rtl/priority_ready_queue_scheduler.sv @@
// Priority ready queue top level: request queue, cell chain, assertions.
// Usage:
//   i_req carries one request (operation, thread_tag, priority_req,
//   new_state) per valid/ready handshake; o_rsp returns exactly one result
//   (status, chosen_tag, chosen_priority, occupancy) per request, in order.
//   Operations: add (sorted insert, FIFO among equals), pop head, pick the
//   first ready entry above a threshold (marked running), set state by tag.
//   A two-entry request queue decouples the input from the cell chain.
//   The cell chain handles one request at a time: the eval state compares
//   every cell against the request and registers the match, then the do
//   state priority-encodes the match, shifts or updates the cells and
//   registers the result. The chain takes no new request until the do
//   state of the current one has registered its result.
//   Reset (synchronous, active low) empties the queue; cell contents stay
//   undefined until written. When o_rsp stalls the result is held and the
//   chain takes no new request until it is accepted; the request queue
//   then fills and drops ready.
module priority_ready_queue_scheduler #(
    parameter int THREADS = 16
) (
    input logic       i_clk,
    input logic       i_rst_n,
    prq_req_if.sink   i_req,
    prq_rsp_if.source o_rsp
);
    logic          q_valid, q_take;
    prq_pkg::t_req q_req;

    prq_front u_front (
        .i_clk, .i_rst_n, .req(i_req),
        .o_valid(q_valid), .o_req(q_req), .i_take(q_take)
    );

    prq_cells #(.THREADS(THREADS)) u_cells (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_req(q_req),
        .o_take(q_take), .rsp(o_rsp)
    );

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.payload.occupancy <= 5'(THREADS)))
        else $error("occupancy above capacity");
    a_full_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.payload.status == prq_pkg::ST_FULL)
        |-> (o_rsp.payload.occupancy == 5'(THREADS)))
        else $error("full reported below capacity");
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.payload.status == prq_pkg::ST_EMPTY)
        |-> (o_rsp.payload.occupancy == 5'd0 && o_rsp.payload.chosen_tag == '0))
        else $error("empty result not clean");
endmodule
